// ----- rtl/core/pwmemt_pkg.sv -----
package pwmemt_pkg;

   // Timer and total widths, used by the word formats below.
   localparam int TIME_WIDTH     = 32;
   localparam int TOTAL_WIDTH    = 48;
   localparam int PULSE_WIDTH    = 16;
   localparam int ANGLE_WIDTH    = 18;
   localparam int STEP_WIDTH     = ANGLE_WIDTH + 2;
   localparam int CSR_DATA_WIDTH = 18;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [PULSE_WIDTH-1:0] MIN_PULSE_RESET = PULSE_WIDTH'(2560);
   localparam logic [ANGLE_WIDTH-1:0] TURN_RESET      = ANGLE_WIDTH'(81920);
   localparam logic [ANGLE_WIDTH-1:0] MAX_STEP_RESET  = ANGLE_WIDTH'(20480);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_PULSE = 2'd0,
      CSR_TURN      = 2'd1,
      CSR_MAX_STEP  = 2'd2,
      CSR_INVERT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  edge_rising;
      logic [TIME_WIDTH-1:0] capture_time;
      logic                  run_enabled;
   } req_word_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]         period_ticks;
      logic [TIME_WIDTH-1:0]         high_time;
      logic [ANGLE_WIDTH-1:0]        instant_angle;
      logic signed [TOTAL_WIDTH-1:0] total_angle;
      logic                          angle_updated;
      logic                          seeded;
   } rsp_word_type;

   // Word after the timing stage: measured times plus whether an angle follows.
   typedef struct packed {
      logic [TIME_WIDTH-1:0] period_ticks;
      logic [TIME_WIDTH-1:0] high_time;
      logic                  do_angle;
   } timing_word_type;

   // Word after the angle stage.
   typedef struct packed {
      logic [TIME_WIDTH-1:0]  period_ticks;
      logic [TIME_WIDTH-1:0]  high_time;
      logic                   do_angle;
      logic [ANGLE_WIDTH-1:0] angle;
   } angle_word_type;

endpackage

// ----- rtl/core/pwm_encoder_multiturn_tracker_unit.sv -----
// Each accepted request word moves in turn through the input, timing, angle and result
// registers. One word per cycle is taken while the result side accepts; a stall there
// backs up through this four-deep register pipeline before req_ready drops.
// Reset (synchronous, active high) empties the pipeline, loads the configuration
// defaults, clears all measurements and the total, and arms first-angle seeding.
module pwm_encoder_multiturn_tracker_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  pwmemt_pkg::req_word_type                  req_word,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output pwmemt_pkg::rsp_word_type                  rsp_word,
   input  logic                                      csr_we,
   input  logic [pwmemt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pwmemt_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import pwmemt_pkg::*;

   // Configuration registers.
   logic [PULSE_WIDTH-1:0] min_pulse_ff;
   logic [ANGLE_WIDTH-1:0] turn_ff;
   logic [ANGLE_WIDTH-1:0] max_step_ff;
   logic                   invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= MIN_PULSE_RESET;
         turn_ff      <= TURN_RESET;
         max_step_ff  <= MAX_STEP_RESET;
         invert_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_PULSE: min_pulse_ff <= csr_wdata[PULSE_WIDTH-1:0];
            CSR_TURN:      turn_ff      <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_MAX_STEP:  max_step_ff  <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_INVERT:    invert_ff    <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   // Pipeline flow control. Each stage loads when it is empty or when the stage
   // after it is loading, so the pipeline runs at full rate until the result
   // register is stalled.
   logic         in_valid_ff, tm_valid_ff, an_valid_ff, rsp_valid_ff;
   req_word_type in_word_ff;
   timing_word_type tm_word_ff, tm_word_in;
   angle_word_type  an_word_ff, an_word_in;
   rsp_word_type    rsp_word_ff, rsp_word_in;

   logic rsp_load, an_load, tm_load, in_load;
   logic tm_fire, an_fire, rsp_fire;

   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign an_load  = !an_valid_ff || rsp_load;
   assign tm_load  = !tm_valid_ff || an_load;
   assign in_load  = !in_valid_ff || tm_load;

   assign tm_fire  = in_valid_ff && tm_load;
   assign an_fire  = tm_valid_ff && an_load;
   assign rsp_fire = an_valid_ff && rsp_load;

   assign req_ready = in_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         tm_valid_ff  <= 1'b0;
         an_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (tm_load) begin
            tm_valid_ff <= in_valid_ff;
         end
         if (an_load) begin
            an_valid_ff <= tm_valid_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= an_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_load) begin
         in_word_ff <= req_word;
      end
      if (tm_fire) begin
         tm_word_ff <= tm_word_in;
      end
      if (an_fire) begin
         an_word_ff <= an_word_in;
      end
      if (rsp_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Timing stage. A rising edge measures the period from the previous rising
   // edge and restarts the reference; a falling edge measures the high time.
   // Until a rising edge has been seen there is no reference, so a rising edge
   // only records its time and a falling edge changes nothing.
   logic [TIME_WIDTH-1:0] last_rise_ff, last_rise_in;
   logic                  rise_seen_ff, rise_seen_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in;
   logic [TIME_WIDTH-1:0] high_ff, high_in;
   logic [TIME_WIDTH-1:0] since_rise;
   logic                  do_angle;

   assign since_rise = in_word_ff.capture_time - last_rise_ff;

   always_comb begin
      last_rise_in = last_rise_ff;
      rise_seen_in = rise_seen_ff;
      period_in    = period_ff;
      high_in      = high_ff;
      do_angle     = 1'b0;
      if (in_word_ff.edge_rising) begin
         if (rise_seen_ff) begin
            period_in = since_rise;
         end
         last_rise_in = in_word_ff.capture_time;
         rise_seen_in = 1'b1;
      end else if (rise_seen_ff) begin
         high_in  = since_rise;
         do_angle = in_word_ff.run_enabled;
      end
      tm_word_in.period_ticks = period_in;
      tm_word_in.high_time    = high_in;
      tm_word_in.do_angle     = do_angle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rise_ff <= '0;
         rise_seen_ff <= 1'b0;
         period_ff    <= '0;
         high_ff      <= '0;
      end else if (tm_fire) begin
         last_rise_ff <= last_rise_in;
         rise_seen_ff <= rise_seen_in;
         period_ff    <= period_in;
         high_ff      <= high_in;
      end
   end

   // Angle stage. The high time above the minimum pulse is clamped to one turn.
   // The subtraction carries an extra bit so a short pulse reads as negative.
   logic [TIME_WIDTH:0]    excess;
   logic [ANGLE_WIDTH-1:0] angle_value;

   assign excess = {1'b0, tm_word_ff.high_time} - (TIME_WIDTH + 1)'(min_pulse_ff);

   always_comb begin
      if (excess[TIME_WIDTH] || (excess == '0)) begin
         angle_value = '0;
      end else if (excess[TIME_WIDTH-1:0] > TIME_WIDTH'(turn_ff)) begin
         angle_value = turn_ff;
      end else begin
         angle_value = excess[ANGLE_WIDTH-1:0];
      end
      an_word_in.period_ticks = tm_word_ff.period_ticks;
      an_word_in.high_time    = tm_word_ff.high_time;
      an_word_in.do_angle     = tm_word_ff.do_angle;
      an_word_in.angle        = angle_value;
   end

   // Unwrap and accumulate stage. The first angle after reset only seeds the
   // reference. Later steps are folded into half a turn either way, dropped if
   // larger than the step limit, optionally negated, and added with saturation.
   logic                          awaiting_first_ff, awaiting_first_in;
   logic [ANGLE_WIDTH-1:0]        prev_angle_ff, prev_angle_in;
   logic signed [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic signed [STEP_WIDTH-1:0]  raw_step, folded_step, gated_step, final_step;
   logic signed [STEP_WIDTH:0]    twice_step, turn_wide;
   logic signed [STEP_WIDTH-1:0]  turn_step, limit_step;
   logic signed [TOTAL_WIDTH:0]   total_sum;
   logic                          updated, seeded;

   localparam logic signed [TOTAL_WIDTH-1:0] TOTAL_MAX = {1'b0, {(TOTAL_WIDTH - 1){1'b1}}};
   localparam logic signed [TOTAL_WIDTH-1:0] TOTAL_MIN = {1'b1, {(TOTAL_WIDTH - 1){1'b0}}};

   assign raw_step   = $signed({2'b00, an_word_ff.angle}) - $signed({2'b00, prev_angle_ff});
   assign twice_step = {raw_step, 1'b0};
   assign turn_wide  = $signed({3'b000, turn_ff});
   assign turn_step  = $signed({2'b00, turn_ff});
   assign limit_step = $signed({2'b00, max_step_ff});

   always_comb begin
      if (twice_step < -turn_wide) begin
         folded_step = raw_step + turn_step;
      end else if (twice_step > turn_wide) begin
         folded_step = raw_step - turn_step;
      end else begin
         folded_step = raw_step;
      end
      if ((folded_step > limit_step) || (folded_step < -limit_step)) begin
         gated_step = '0;
      end else begin
         gated_step = folded_step;
      end
      final_step = invert_ff ? -gated_step : gated_step;
   end

   assign total_sum = {total_ff[TOTAL_WIDTH-1], total_ff}
                    + {{(TOTAL_WIDTH + 1 - STEP_WIDTH){final_step[STEP_WIDTH-1]}}, final_step};

   always_comb begin
      awaiting_first_in = awaiting_first_ff;
      prev_angle_in     = prev_angle_ff;
      total_in          = total_ff;
      updated           = 1'b0;
      seeded            = 1'b0;
      if (an_word_ff.do_angle) begin
         if (awaiting_first_ff) begin
            total_in          = '0;
            awaiting_first_in = 1'b0;
            seeded            = 1'b1;
         end else begin
            if (total_sum[TOTAL_WIDTH] != total_sum[TOTAL_WIDTH-1]) begin
               total_in = total_sum[TOTAL_WIDTH] ? TOTAL_MIN : TOTAL_MAX;
            end else begin
               total_in = total_sum[TOTAL_WIDTH-1:0];
            end
            updated = 1'b1;
         end
         prev_angle_in = an_word_ff.angle;
      end
      rsp_word_in.period_ticks  = an_word_ff.period_ticks;
      rsp_word_in.high_time     = an_word_ff.high_time;
      rsp_word_in.instant_angle = prev_angle_in;
      rsp_word_in.total_angle   = total_in;
      rsp_word_in.angle_updated = updated;
      rsp_word_in.seeded        = seeded;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_first_ff <= 1'b1;
         prev_angle_ff     <= '0;
         total_ff          <= '0;
      end else if (rsp_fire) begin
         awaiting_first_ff <= awaiting_first_in;
         prev_angle_ff     <= prev_angle_in;
         total_ff          <= total_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A word either seeds the reference or adds a step, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_word_ff.seeded && rsp_word_ff.angle_updated))
      else $error("result word both seeded and updated");

   // Once an angle has been taken, seeding is disarmed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && an_word_ff.do_angle) |=> !awaiting_first_ff)
      else $error("seeding still armed after an angle");

   // The total only moves when an angle is processed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !an_word_ff.do_angle) |=> $stable(total_ff))
      else $error("total changed without an angle");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif

endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pwmemt_pkg::*;

   // A stall this long with no word moving on either channel means the block is hung.
   localparam int QUIET_LIMIT = 4000;
   localparam int DIRECTED_ROWS = 25;

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   pwm_encoder_multiturn_tracker_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Shadow copy of the configuration registers, loaded with their reset values.
   logic [PULSE_WIDTH-1:0] min_pulse_cfg = MIN_PULSE_RESET;
   logic [ANGLE_WIDTH-1:0] turn_cfg = TURN_RESET;
   logic [ANGLE_WIDTH-1:0] max_step_cfg = MAX_STEP_RESET;
   logic invert_cfg = 1'b0;

   // Tracker state as the block should hold it after every accepted word.
   logic [TIME_WIDTH-1:0] last_rise_q = '0;
   logic rise_seen_q = 1'b0;
   logic [TIME_WIDTH-1:0] period_q = '0;
   logic [TIME_WIDTH-1:0] high_q = '0;
   logic awaiting_seed_q = 1'b1;
   logic [ANGLE_WIDTH-1:0] angle_q = '0;
   logic signed [TOTAL_WIDTH-1:0] total_q = '0;

   // Readings the block still owes us, oldest first.
   rsp_word_type pending_readings[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int reading_count = 0;
   int quiet_cycles = 0;

   // Free-running sensor model used to build plausible pulse trains.
   logic [TIME_WIDTH-1:0] timer_now;
   longint sensor_angle = 0;

   // One row of the directed script: the request word, and optionally a reading
   // typed in by hand where it is obvious from the tracker's rules.
   typedef struct packed {
      req_word_type word;
      logic known;
      rsp_word_type reading;
   } script_row_type;

   script_row_type directed_rows [DIRECTED_ROWS];

   // Advance the tracker by one capture event and return the reading it produces.
   function automatic rsp_word_type track_capture(input req_word_type w);
      rsp_word_type r;
      logic [TIME_WIDTH-1:0] excess;
      logic [ANGLE_WIDTH-1:0] angle;
      logic signed [STEP_WIDTH-1:0] step;
      logic signed [STEP_WIDTH-1:0] twice;
      logic signed [STEP_WIDTH-1:0] turn_s;
      logic signed [STEP_WIDTH-1:0] lim_s;
      logic signed [TOTAL_WIDTH:0] sum;
      r = '0;
      if (w.edge_rising) begin
         // The very first rising edge has nothing to measure a period against.
         if (rise_seen_q) period_q = w.capture_time - last_rise_q;
         last_rise_q = w.capture_time;
         rise_seen_q = 1'b1;
      end else if (rise_seen_q) begin
         high_q = w.capture_time - last_rise_q;
         if (w.run_enabled) begin
            // Angle is the high time above the minimum pulse, clamped to one turn.
            if (high_q <= TIME_WIDTH'(min_pulse_cfg)) begin
               angle = '0;
            end else begin
               excess = high_q - TIME_WIDTH'(min_pulse_cfg);
               angle = (excess > TIME_WIDTH'(turn_cfg)) ? turn_cfg
                                                        : excess[ANGLE_WIDTH-1:0];
            end
            if (awaiting_seed_q) begin
               total_q = '0;
               awaiting_seed_q = 1'b0;
               r.seeded = 1'b1;
            end else begin
               step = $signed({2'b00, angle}) - $signed({2'b00, angle_q});
               twice = step <<< 1;
               turn_s = $signed({2'b00, turn_cfg});
               lim_s = $signed({2'b00, max_step_cfg});
               // Unwrap across half a turn, then drop implausibly large jumps.
               if (twice < -turn_s) step = step + turn_s;
               else if (twice > turn_s) step = step - turn_s;
               if (step > lim_s || step < -lim_s) step = '0;
               if (invert_cfg) step = -step;
               sum = total_q + step;
               if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1]) begin
                  total_q = sum[TOTAL_WIDTH] ? {1'b1, {(TOTAL_WIDTH-1){1'b0}}}
                                             : {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
               end else begin
                  total_q = sum[TOTAL_WIDTH-1:0];
               end
               r.angle_updated = 1'b1;
            end
            angle_q = angle;
         end
      end
      r.period_ticks = period_q;
      r.high_time = high_q;
      r.instant_angle = angle_q;
      r.total_angle = total_q;
      return r;
   endfunction

   function automatic script_row_type row(input logic rising, input logic [TIME_WIDTH-1:0] t,
                                          input logic run);
      script_row_type s;
      s = '0;
      s.word.edge_rising = rising;
      s.word.capture_time = t;
      s.word.run_enabled = run;
      return s;
   endfunction

   function automatic script_row_type row_known(input logic rising,
                                                input logic [TIME_WIDTH-1:0] t,
                                                input logic run,
                                                input logic [TIME_WIDTH-1:0] period,
                                                input logic [TIME_WIDTH-1:0] high,
                                                input logic [ANGLE_WIDTH-1:0] angle,
                                                input logic signed [TOTAL_WIDTH-1:0] total,
                                                input logic updated,
                                                input logic seeded);
      script_row_type s;
      s = row(rising, t, run);
      s.known = 1'b1;
      s.reading.period_ticks = period;
      s.reading.high_time = high;
      s.reading.instant_angle = angle;
      s.reading.total_angle = total;
      s.reading.angle_updated = updated;
      s.reading.seeded = seeded;
      return s;
   endfunction

   // Present one word, with random idle cycles in front of it, and hold it until the
   // block takes it. Called in the time step of the previous acceptance, so valid is
   // either kept high for this word or lowered for a gap, never both.
   task automatic send_word(input req_word_type w, input logic known,
                            input rsp_word_type reading);
      rsp_word_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      predicted = track_capture(w);
      pending_readings.push_back(known ? reading : predicted);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MIN_PULSE: min_pulse_cfg = value[PULSE_WIDTH-1:0];
         CSR_TURN:      turn_cfg = value[ANGLE_WIDTH-1:0];
         CSR_MAX_STEP:  max_step_cfg = value[ANGLE_WIDTH-1:0];
         CSR_INVERT:    invert_cfg = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // One phase: drain, reprogram all four registers, then stream random words.
   // Most words are well-formed rising/falling pairs from a sensor that turns in
   // small steps; the rest are pairs with oversized jumps or out-of-range pulses,
   // and stray words with arbitrary timestamps.
   task automatic run_phase(input int send_idle, input int stall,
                            input logic [CSR_DATA_WIDTH-1:0] min_v,
                            input logic [CSR_DATA_WIDTH-1:0] turn_v,
                            input logic [CSR_DATA_WIDTH-1:0] max_v,
                            input logic [CSR_DATA_WIDTH-1:0] inv_v,
                            input int words);
      longint span;
      longint lim;
      longint step;
      longint high;
      int sent;
      int pick;
      req_word_type w;
      req_valid <= 1'b0;
      // Every word yields one reading, so an empty queue means the block is idle.
      while (pending_readings.size() != 0) @(posedge clock);
      write_csr(CSR_MIN_PULSE, min_v);
      write_csr(CSR_TURN, turn_v);
      write_csr(CSR_MAX_STEP, max_v);
      write_csr(CSR_INVERT, inv_v);
      csr_we <= 1'b0;
      send_idle_pct = send_idle;
      stall_pct = stall;
      lim = longint'(max_step_cfg);
      span = (turn_cfg == '0) ? 1 : longint'(turn_cfg);
      sensor_angle = sensor_angle % span;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
               step = longint'($urandom_range(2 * lim)) - lim;
            end else if (pick < 8) begin
               step = lim + 1 + longint'($urandom_range(span));
               if ($urandom_range(1) == 0) step = -step;
            end else begin
               step = longint'($urandom_range(span));
            end
            sensor_angle = ((sensor_angle + step) % span + span) % span;
            pick = $urandom_range(9);
            if (pick == 0) begin
               high = longint'($urandom_range(min_pulse_cfg));
            end else if (pick == 1) begin
               high = longint'(min_pulse_cfg) + longint'(turn_cfg) + 1
                      + longint'($urandom_range(4095));
            end else begin
               high = longint'(min_pulse_cfg) + sensor_angle;
            end
            w.edge_rising = 1'b1;
            w.capture_time = timer_now;
            w.run_enabled = 1'($urandom_range(1));
            send_word(w, 1'b0, '0);
            w.edge_rising = 1'b0;
            w.capture_time = timer_now + high[TIME_WIDTH-1:0];
            w.run_enabled = ($urandom_range(9) != 0);
            send_word(w, 1'b0, '0);
            timer_now = timer_now + high[TIME_WIDTH-1:0] + TIME_WIDTH'($urandom_range(262143, 1));
            sent += 2;
         end else begin
            w.edge_rising = 1'($urandom_range(1));
            w.capture_time = $urandom;
            w.run_enabled = 1'($urandom_range(1));
            send_word(w, 1'b0, '0);
            sent += 1;
         end
      end
   endtask

   // Result side: check every word the block hands over against the oldest
   // expectation, then pick this cycle's ready for the next edge.
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      string bad_fields;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            reading_count++;
            if (pending_readings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("reading %0d arrived with nothing expected", reading_count);
            end else begin
               want = pending_readings.pop_front();
               bad_fields = "";
               if (rsp_word.period_ticks !== want.period_ticks)
                  bad_fields = {bad_fields, " period_ticks"};
               if (rsp_word.high_time !== want.high_time)
                  bad_fields = {bad_fields, " high_time"};
               if (rsp_word.instant_angle !== want.instant_angle)
                  bad_fields = {bad_fields, " instant_angle"};
               if (rsp_word.total_angle !== want.total_angle)
                  bad_fields = {bad_fields, " total_angle"};
               if (rsp_word.angle_updated !== want.angle_updated)
                  bad_fields = {bad_fields, " angle_updated"};
               if (rsp_word.seeded !== want.seeded)
                  bad_fields = {bad_fields, " seeded"};
               if (bad_fields != "") begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("reading %0d wrong in%s", reading_count, bad_fields);
                     $display("  expected period %h high %h angle %h total %h upd %b seed %b",
                              want.period_ticks, want.high_time, want.instant_angle,
                              want.total_angle, want.angle_updated, want.seeded);
                     $display("  actual   period %h high %h angle %h total %h upd %b seed %b",
                              rsp_word.period_ticks, rsp_word.high_time,
                              rsp_word.instant_angle, rsp_word.total_angle,
                              rsp_word.angle_updated, rsp_word.seeded);
                  end
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: the run is hung if no word moves for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      timer_now = $urandom;

      // Directed script, run with the reset configuration (min pulse 2560,
      // one turn 81920 ticks, largest step 20480, no inversion).
      // A falling edge before any rising edge is ignored entirely.
      directed_rows[0]  = row_known(1'b0, 32'hFFFF_FFFF, 1'b1, 0, 0, 0, 0, 1'b0, 1'b0);
      // A rising edge at timestamp zero counts as seen; no period yet.
      directed_rows[1]  = row_known(1'b1, 32'd0, 1'b1, 0, 0, 0, 0, 1'b0, 1'b0);
      // With run off, a falling edge only records the high time.
      directed_rows[2]  = row_known(1'b0, 32'd50, 1'b0, 0, 50, 0, 0, 1'b0, 1'b0);
      directed_rows[3]  = row_known(1'b1, 32'd100000, 1'b0, 100000, 50, 0, 0, 1'b0, 1'b0);
      directed_rows[4]  = row_known(1'b0, 32'd143520, 1'b0, 100000, 43520, 0, 0, 1'b0, 1'b0);
      // First falling edge with run on seeds the reference angle.
      directed_rows[5]  = row_known(1'b0, 32'd143520, 1'b1, 100000, 43520, 40960, 0, 1'b0, 1'b1);
      directed_rows[6]  = row_known(1'b1, 32'd200000, 1'b1, 100000, 43520, 40960, 0, 1'b0, 1'b0);
      // Small step forward, then a step just inside the limit, then one just outside.
      directed_rows[7]  = row(1'b0, 32'd244520, 1'b1);
      directed_rows[8]  = row(1'b1, 32'd300000, 1'b1);
      directed_rows[9]  = row(1'b0, 32'd362560, 1'b1);
      directed_rows[10] = row(1'b1, 32'd400000, 1'b1);
      directed_rows[11] = row(1'b0, 32'd483560, 1'b1);
      // Crossing zero upward, then back downward across the turn boundary.
      directed_rows[12] = row(1'b1, 32'd500000, 1'b0);
      directed_rows[13] = row(1'b0, 32'd503060, 1'b1);
      directed_rows[14] = row(1'b1, 32'd600000, 1'b1);
      directed_rows[15] = row(1'b0, 32'd684060, 1'b1);
      // High time below the minimum pulse maps to angle zero; far above it clamps.
      directed_rows[16] = row(1'b1, 32'd700000, 1'b1);
      directed_rows[17] = row(1'b0, 32'd701000, 1'b1);
      directed_rows[18] = row(1'b1, 32'd800000, 1'b1);
      directed_rows[19] = row(1'b0, 32'd1000000, 1'b1);
      // High time exactly at the minimum pulse.
      directed_rows[20] = row(1'b1, 32'h1000_0000, 1'b1);
      directed_rows[21] = row(1'b0, 32'h1000_0A00, 1'b1);
      // Timer wrap between the rising and falling edges, and the largest timestamp.
      directed_rows[22] = row(1'b1, 32'hFFFF_FFF0, 1'b1);
      directed_rows[23] = row(1'b0, 32'h0000_0100, 1'b1);
      directed_rows[24] = row(1'b0, 32'hFFFF_FFFF, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].reading);

      // Random phases. Each sweeps a different configuration and a different
      // idling pattern: none, sender idle 77%, receiver stalling 77%, both 31%.
      // Extremes: zero and full-width values, degenerate turns of 0 and 1, and
      // writes with bits above a register's width set.
      run_phase(0, 0, 18'd2560, 18'd81920, 18'd20480, 18'd0, 222);
      run_phase(77, 0, 18'd0, 18'h3FFFF, 18'h3FFFF, 18'd1, 222);
      run_phase(0, 77, 18'h3FFFF, 18'd2, 18'd0, 18'd0, 222);
      run_phase(31, 31, 18'd1000, 18'd4096, 18'd1024, 18'h3FFFF, 222);
      run_phase(0, 0, 18'd100, 18'd0, 18'd3, 18'd2, 222);
      run_phase(77, 0, 18'd65535, 18'd1, 18'h3FFFF, 18'd1, 222);
      run_phase(0, 77, CSR_DATA_WIDTH'($urandom_range(65535)),
                CSR_DATA_WIDTH'($urandom_range(262143, 2)),
                CSR_DATA_WIDTH'($urandom_range(262143)),
                CSR_DATA_WIDTH'($urandom_range(1)), 222);
      run_phase(31, 31, CSR_DATA_WIDTH'($urandom_range(65535)),
                CSR_DATA_WIDTH'($urandom_range(8192, 2)),
                CSR_DATA_WIDTH'($urandom_range(4096)),
                CSR_DATA_WIDTH'($urandom_range(1)), 222);
      req_valid <= 1'b0;

      // Drain, then give any stray reading time to show up.
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
